// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check on every rising edge, disabled while reset is asserted.
`define BIS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check on every rising edge, reset included.
`define BIS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define BIS_ASSERT(name, clk, rst_n, prop)
`define BIS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- rtl/core/bis_pkg.sv -----
// ---------------------------------------------------------------------------
// bis_pkg
// Widths, operation codes and shared types of the bitmap integer set.
// ---------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ELEM_W   = 10;
  localparam int unsigned COUNT_W  = 11;
  // Storage lines are 32 bits; the line index is the upper part of an element.
  localparam int unsigned LINE_W   = 32;
  localparam int unsigned LINE_BW  = 5;
  localparam int unsigned LINE_AW  = ELEM_W - LINE_BW;
  localparam int unsigned ELEM_SPAN = 1 << ELEM_W;

  localparam int unsigned DEF_WORD_BITS = 32;
  localparam int unsigned DEF_NUM_WORDS = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_TEST   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_NEXT   = 3'd4,
    KIND_FIRST  = 3'd5
  } kind_e;

  // Command strobes from the sequencer to the line store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } mem_cmd_t;

endpackage

// ----- rtl/core/bis_mem.sv -----
// ---------------------------------------------------------------------------
// bis_mem
// Line store with registered read and per-line valid bits; invalid reads zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bis_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bis_pkg::mem_cmd_t         cmd_i,
  input  logic [AW-1:0]             rd_addr_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [bis_pkg::LINE_W-1:0] wr_data_i,
  output logic [bis_pkg::LINE_W-1:0] rd_data_o
);
  import bis_pkg::*;

  logic [LINE_W-1:0] mem_q [DEPTH];
  logic [LINE_W-1:0] rdata_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Clear drops every line at once; a write marks its line valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

  `BIS_ASSERT(a_no_wr_with_clr, clk_i, rst_ni, !(cmd_i.wr && cmd_i.clr))
  `BIS_ASSERT(a_no_rd_with_wr, clk_i, rst_ni, !(cmd_i.rd && (cmd_i.wr || cmd_i.clr)))
  `BIS_ASSERT(a_wr_marks_valid, clk_i, rst_ni, cmd_i.wr |=> vld_q[$past(wr_addr_i)])

endmodule

// ----- rtl/core/bitmap_integer_set.sv -----
// ---------------------------------------------------------------------------
// bitmap_integer_set
// Integer set over a bounded universe, kept as a bitmap in a line store.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries kind_i and element_i:
//   add, remove, test, clear all, next member above element, first member.
//   Each transfer gives exactly one result on the output channel
//   (out_valid_o / out_ready_i): prior membership, member count after the
//   operation, and for searches a found flag with the member found.
//   One item is in work at a time; in_ready_o is high only while idle, so
//   a new item is taken only after the last one has loaded its result.
//   Add, remove, test, clear and the unused codes read the store line,
//   then modify, write back and load the result. A search reads the line
//   of the element, then scans L 32-bit lines (0 above the top element,
//   else 1 to the store depth), one line per cycle as set by the single
//   read port. Reset clears the per-line valid bits, so the store reads
//   as an empty set at once; no clearing pass is run. Clear all drops
//   every valid bit at once.
//   A result waits in the output register while the receiver stalls; the
//   next item is still taken and does its reads, then holds its write-back
//   and result until the output register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_integer_set #(
  parameter int unsigned WORD_BITS = bis_pkg::DEF_WORD_BITS,
  parameter int unsigned NUM_WORDS = bis_pkg::DEF_NUM_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bis_pkg::KIND_W-1:0]  kind_i,
  input  logic [bis_pkg::ELEM_W-1:0]  element_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        was_member_o,
  output logic [bis_pkg::COUNT_W-1:0] member_count_o,
  output logic                        found_o,
  output logic [bis_pkg::ELEM_W-1:0]  found_element_o
);
  import bis_pkg::*;

  // Only the first 1024 elements can be named, so the store never needs more.
  localparam int unsigned UNIV      = WORD_BITS * NUM_WORDS;
  localparam int unsigned UNIV_EFF  = (UNIV < ELEM_SPAN) ? UNIV : ELEM_SPAN;
  localparam int unsigned MEM_DEPTH = (UNIV_EFF + LINE_W - 1) / LINE_W;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [COUNT_W-1:0] UNIV_W    = COUNT_W'(UNIV_EFF);
  localparam logic [LINE_AW-1:0] LAST_LINE = LINE_AW'(MEM_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_OP   = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  // Index of the lowest set bit; isolate it, then encode the one-hot.
  function automatic logic [LINE_BW-1:0] low_index(input logic [LINE_W-1:0] x);
    logic [LINE_W-1:0]  low;
    logic [LINE_BW-1:0] idx;
    low = x & (~x + LINE_W'(1));
    idx = '0;
    for (int i = 0; i < LINE_W; i++) begin
      if (low[i]) begin
        idx = idx | LINE_BW'(i);
      end
    end
    return idx;
  endfunction

  state_e              state_q, state_d;
  kind_e               kind_q;
  logic [ELEM_W-1:0]   elem_q;
  logic                univ_q;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [LINE_AW-1:0]  scan_q, scan_d;
  logic [LINE_W-1:0]   mask_q, mask_d;
  logic                was_hold_q, was_hold_d;

  logic                out_vld_q;
  logic                res_was_q, res_was_d;
  logic [COUNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic                res_fnd_q, res_fnd_d;
  logic [ELEM_W-1:0]   res_elem_q, res_elem_d;
  logic                load_out;

  mem_cmd_t            cmd;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [LINE_W-1:0]   wr_data, word;

  logic                accept, out_free;
  logic [LINE_AW-1:0]  in_line, elem_line, start_line;
  logic                in_ok, was_bit, is_search, start_ok, hit;
  logic [COUNT_W-1:0]  start;
  logic [LINE_W-1:0]   onehot, hit_word;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  assign in_line    = element_i[ELEM_W-1:LINE_BW];
  assign in_ok      = {1'b0, element_i} < UNIV_W;
  assign elem_line  = elem_q[ELEM_W-1:LINE_BW];
  assign onehot     = LINE_W'(1) << elem_q[LINE_BW-1:0];
  assign was_bit    = univ_q && word[elem_q[LINE_BW-1:0]];
  assign is_search  = (kind_q == KIND_NEXT) || (kind_q == KIND_FIRST);
  assign start      = {1'b0, elem_q} + COUNT_W'(1);
  assign start_ok   = start < UNIV_W;
  assign start_line = start[ELEM_W-1:LINE_BW];
  assign hit_word   = word & mask_q;
  assign hit        = |hit_word;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    mask_d     = mask_q;
    was_hold_d = was_hold_q;
    cmd        = '0;
    rd_addr    = '0;
    wr_addr    = elem_line[AW-1:0];
    wr_data    = word;
    load_out   = 1'b0;
    res_was_d  = was_bit;
    res_cnt_d  = count_q;
    res_fnd_d  = 1'b0;
    res_elem_d = '0;

    case (state_q)
      ST_IDLE: begin
        // Read the line holding the element; a clamp keeps the address in range.
        if (accept) begin
          cmd.rd  = 1'b1;
          rd_addr = in_ok ? in_line[AW-1:0] : '0;
          state_d = ST_OP;
        end
      end

      ST_OP: begin
        if (is_search) begin
          was_hold_d = was_bit;
          if (kind_q == KIND_NEXT && !start_ok) begin
            // Nothing lies above the top of the universe.
            if (out_free) begin
              load_out = 1'b1;
              state_d  = ST_IDLE;
            end
          end else begin
            cmd.rd = 1'b1;
            if (kind_q == KIND_FIRST) begin
              scan_d = '0;
              mask_d = '1;
            end else begin
              scan_d = start_line;
              mask_d = {LINE_W{1'b1}} << start[LINE_BW-1:0];
            end
            rd_addr = scan_d[AW-1:0];
            state_d = ST_SCAN;
          end
        end else if (out_free) begin
          // Commit the change together with the result.
          case (kind_q)
            KIND_ADD: begin
              if (univ_q && !was_bit) begin
                cmd.wr  = 1'b1;
                wr_data = word | onehot;
                count_d = count_q + COUNT_W'(1);
              end
            end
            KIND_REMOVE: begin
              if (was_bit) begin
                cmd.wr  = 1'b1;
                wr_data = word & ~onehot;
                count_d = count_q - COUNT_W'(1);
              end
            end
            KIND_CLEAR: begin
              cmd.clr = 1'b1;
              count_d = '0;
            end
            default: begin
            end
          endcase
          res_cnt_d = count_d;
          load_out  = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_SCAN: begin
        res_was_d = was_hold_q;
        if (hit || scan_q == LAST_LINE) begin
          // Hold the line data until the output register frees.
          if (out_free) begin
            res_fnd_d  = hit;
            res_elem_d = hit ? {scan_q, low_index(hit_word)} : '0;
            load_out   = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          // Advance to the next line; only the first line is masked.
          cmd.rd  = 1'b1;
          scan_d  = scan_q + LINE_AW'(1);
          mask_d  = '1;
          rd_addr = scan_d[AW-1:0];
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      elem_q <= element_i;
      univ_q <= in_ok;
    end
    scan_q     <= scan_d;
    mask_q     <= mask_d;
    was_hold_q <= was_hold_d;
    if (load_out) begin
      res_was_q  <= res_was_d;
      res_cnt_q  <= res_cnt_d;
      res_fnd_q  <= res_fnd_d;
      res_elem_q <= res_elem_d;
    end
  end

  bis_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (word)
  );

  assign out_valid_o     = out_vld_q;
  assign was_member_o    = res_was_q;
  assign member_count_o  = res_cnt_q;
  assign found_o         = res_fnd_q;
  assign found_element_o = res_elem_q;

  `BIS_ASSERT(a_accept_to_op, clk_i, rst_ni, accept |=> state_q == ST_OP)
  `BIS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= UNIV_W)
  `BIS_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN) |-> (scan_q <= LAST_LINE))
  `BIS_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_vld_q && !out_ready_i) |-> !load_out)

endmodule

// ----- bench/tb_bitmap_integer_set.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bitmap_integer_set
// Self-checking bench for the bitmap integer set. A directed table covers
// the empty set, the universe edges, redundant updates, the search corner
// cases and the unused codes. Random traffic then works in windows that
// grow and shrink the set. A behavioral copy of the set predicts every
// result, and the output channel is scoreboarded in order.
// ---------------------------------------------------------------------------
module tb_bitmap_integer_set;
  import bis_pkg::*;

  // Codes 6 and 7 have no operation; the block treats them like a test.
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
  localparam int unsigned TOP_ELEM     = ELEM_SPAN - 1;
  localparam int unsigned PHASE_ITEMS  = 640;
  localparam int unsigned WINDOW_ITEMS = 40;
  // Longest search walks every line once, plus the first read and the result load.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic                was_member;
    logic [COUNT_W-1:0]  member_count;
    logic                found;
    logic [ELEM_W-1:0]   found_element;
  } set_result_t;

  // One directed row: the operation, and optionally a hand-written answer.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ELEM_W-1:0] elem;
    logic              typed;
    set_result_t       answer;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [KIND_W-1:0]   kind_i      = KIND_TEST;
  logic [ELEM_W-1:0]   element_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                was_member_o;
  logic [COUNT_W-1:0]  member_count_o;
  logic                found_o;
  logic [ELEM_W-1:0]   found_element_o;

  // Predicted contents of the set.
  logic [ELEM_SPAN-1:0] member_bits  = '0;
  logic [COUNT_W-1:0]   member_total = '0;
  int unsigned          peak_total   = 0;

  set_result_t pending_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned report_count  = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen     = 0;
  int unsigned kind_tally [0:7];

  dir_row_t dir_tab [0:21];

  bitmap_integer_set u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .element_i       (element_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .was_member_o    (was_member_o),
    .member_count_o  (member_count_o),
    .found_o         (found_o),
    .found_element_o (found_element_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the predicted set and return its result.
  function automatic set_result_t apply_set_op(input logic [KIND_W-1:0] k,
                                               input logic [ELEM_W-1:0] e);
    set_result_t r;
    int unsigned idx;
    r = '0;
    r.was_member = member_bits[e];
    case (k)
      KIND_ADD: begin
        if (!member_bits[e]) begin
          member_bits[e] = 1'b1;
          member_total   = member_total + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (member_bits[e]) begin
          member_bits[e] = 1'b0;
          member_total   = member_total - 1'b1;
        end
      end
      KIND_CLEAR: begin
        member_bits  = '0;
        member_total = '0;
      end
      KIND_NEXT: begin
        // Search strictly above the element; nothing lies above the top.
        for (idx = {22'd0, e} + 1; idx < ELEM_SPAN && !r.found; idx++) begin
          if (member_bits[idx]) begin
            r.found         = 1'b1;
            r.found_element = idx[ELEM_W-1:0];
          end
        end
      end
      KIND_FIRST: begin
        for (idx = 0; idx < ELEM_SPAN && !r.found; idx++) begin
          if (member_bits[idx]) begin
            r.found         = 1'b1;
            r.found_element = idx[ELEM_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.member_count = member_total;
    if (member_total > peak_total) peak_total = 32'(member_total);
    return r;
  endfunction

  // Present one item from the falling edge, hold it until the transfer,
  // then queue its expected result. Leaves the caller at a falling edge.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [ELEM_W-1:0] e,
                           input logic typed, input set_result_t answer);
    set_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i     = k;
    element_i  = e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_set_op(k, e);
    pending_results.push_back(typed ? answer : predicted);
    kind_tally[k]++;
    @(negedge clk_i);
  endtask

  // Receiver: stall at random, re-rolled every cycle from the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin : score
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: result with nothing pending: was=%0b cnt=%0d fnd=%0b el=%0d",
                   $realtime, was_member_o, member_count_o, found_o, found_element_o);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (found_o === 1'b1) hits_seen++;
        if (was_member_o !== want.was_member || member_count_o !== want.member_count ||
            found_o !== want.found || found_element_o !== want.found_element) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: mismatch exp was=%0b cnt=%0d fnd=%0b el=%0d",
                     $realtime, want.was_member, want.member_count, want.found,
                     want.found_element);
            $display("%0t:          got was=%0b cnt=%0d fnd=%0b el=%0d",
                     $realtime, was_member_o, member_count_o, found_o, found_element_o);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      n;
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      add_share;
    int unsigned      win_span;
    logic [ELEM_W-1:0] win_lo;
    logic [KIND_W-1:0] k;
    logic [ELEM_W-1:0] e;

    for (n = 0; n < 8; n++) kind_tally[n] = 0;

    // Directed rows. Typed answers follow from the set contents by hand;
    // the boundary and bit-pattern rows defer to the predictor.
    dir_tab[0]  = '{KIND_TEST,   10'd0,    1'b1, '{1'b0, 11'd0, 1'b0, 10'd0}};
    dir_tab[1]  = '{KIND_FIRST,  10'd0,    1'b1, '{1'b0, 11'd0, 1'b0, 10'd0}};
    dir_tab[2]  = '{KIND_NEXT,   10'd1023, 1'b1, '{1'b0, 11'd0, 1'b0, 10'd0}};
    dir_tab[3]  = '{KIND_ADD,    10'd0,    1'b1, '{1'b0, 11'd1, 1'b0, 10'd0}};
    dir_tab[4]  = '{KIND_ADD,    10'd1023, 1'b1, '{1'b0, 11'd2, 1'b0, 10'd0}};
    dir_tab[5]  = '{KIND_ADD,    10'd0,    1'b1, '{1'b1, 11'd2, 1'b0, 10'd0}};
    dir_tab[6]  = '{KIND_FIRST,  10'd5,    1'b1, '{1'b0, 11'd2, 1'b1, 10'd0}};
    dir_tab[7]  = '{KIND_NEXT,   10'd0,    1'b1, '{1'b1, 11'd2, 1'b1, 10'd1023}};
    dir_tab[8]  = '{KIND_NEXT,   10'd1023, 1'b1, '{1'b1, 11'd2, 1'b0, 10'd0}};
    dir_tab[9]  = '{KIND_NEXT,   10'd1022, 1'b1, '{1'b0, 11'd2, 1'b1, 10'd1023}};
    dir_tab[10] = '{KIND_REMOVE, 10'd5,    1'b1, '{1'b0, 11'd2, 1'b0, 10'd0}};
    dir_tab[11] = '{KIND_REMOVE, 10'd0,    1'b1, '{1'b1, 11'd1, 1'b0, 10'd0}};
    dir_tab[12] = '{KIND_RSVD6,  10'd1023, 1'b1, '{1'b1, 11'd1, 1'b0, 10'd0}};
    dir_tab[13] = '{KIND_RSVD7,  10'd0,    1'b1, '{1'b0, 11'd1, 1'b0, 10'd0}};
    // Line boundary and alternating element bits.
    dir_tab[14] = '{KIND_ADD,    10'd31,   1'b0, '0};
    dir_tab[15] = '{KIND_ADD,    10'd32,   1'b0, '0};
    dir_tab[16] = '{KIND_NEXT,   10'd31,   1'b0, '0};
    dir_tab[17] = '{KIND_ADD,    10'h2AA,  1'b0, '0};
    dir_tab[18] = '{KIND_ADD,    10'h155,  1'b0, '0};
    dir_tab[19] = '{KIND_NEXT,   10'd32,   1'b0, '0};
    dir_tab[20] = '{KIND_CLEAR,  10'd1023, 1'b1, '{1'b1, 11'd0, 1'b0, 10'd0}};
    dir_tab[21] = '{KIND_FIRST,  10'd1023, 1'b1, '{1'b0, 11'd0, 1'b0, 10'd0}};

    // Hold reset, then release it on a falling edge.
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 53;
    for (n = 0; n < 22; n++) begin
      send_item(dir_tab[n].kind, dir_tab[n].elem, dir_tab[n].typed, dir_tab[n].answer);
    end

    // Random traffic in three idling phases. Each window picks a region of
    // the universe and a bias toward growing, churning or draining the set.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 19; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % WINDOW_ITEMS == 0) begin
          win_lo = ELEM_W'($urandom_range(TOP_ELEM));
          case ($urandom_range(3))
            0: win_span = 31;
            1: win_span = 63;
            2: win_span = 255;
            default: win_span = TOP_ELEM;
          endcase
          case ($urandom_range(2))
            0: add_share = 50;
            1: add_share = 33;
            default: add_share = 15;
          endcase
        end
        roll = $urandom_range(99);
        if (roll < 1)       k = KIND_CLEAR;
        else if (roll < 3)  k = $urandom_range(1) ? KIND_RSVD7 : KIND_RSVD6;
        else if (roll < 8)  k = KIND_FIRST;
        else if (roll < 23) k = KIND_NEXT;
        else if (roll < 35) k = KIND_TEST;
        else if (roll < 35 + add_share) k = KIND_ADD;
        else                k = KIND_REMOVE;
        pick = $urandom_range(99);
        if (pick < 70) begin
          e = ELEM_W'(win_lo + $urandom_range(win_span));
        end else if (pick < 85) begin
          case ($urandom_range(3))
            0: e = '0;
            1: e = ELEM_W'(TOP_ELEM);
            2: e = ELEM_W'(TOP_ELEM - 1);
            default: e = 10'd32;
          endcase
        end else begin
          e = ELEM_W'($urandom_range(TOP_ELEM));
        end
        send_item(k, e, 1'b0, '0);
      end
    end
    in_valid_i = 1'b0;

    // Drain: wait for every pending result, then give a stray one time to show.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) error_count++;
    $display("Covered: add %0d, remove %0d, test %0d, clear %0d, next %0d, first %0d, spare %0d",
             kind_tally[KIND_ADD], kind_tally[KIND_REMOVE], kind_tally[KIND_TEST],
             kind_tally[KIND_CLEAR], kind_tally[KIND_NEXT], kind_tally[KIND_FIRST],
             kind_tally[KIND_RSVD6] + kind_tally[KIND_RSVD7]);
    $display("Results compared %0d, search hits %0d, peak membership %0d, errors %0d",
             results_checked, hits_seen, peak_total, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (searches plus heavy stalls).
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
